// ----- src/sample_voice_resampler_macros.svh -----
// Assertion helpers shared by the voice RTL. Both sample on clk and are
// disabled while rst_n is low.
`ifndef SAMPLE_VOICE_RESAMPLER_MACROS_SVH
`define SAMPLE_VOICE_RESAMPLER_MACROS_SVH

// Same-cycle implication.
`define SVR_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define SVR_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/svr_pkg.sv -----
`timescale 1ns / 1ps
package svr_pkg;

  localparam int DEF_SAMPLE_DEPTH  = 4096;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int ACTION_W   = 3;
  localparam int LOAD_ADDR_W = 12;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 19;
  localparam int FC_W       = 13;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  // Integer cursor part is one bit wider than the frame count.
  localparam int POS_INT_W  = FC_W + 1;
  localparam int DIV_STEPS  = POS_INT_W;
  localparam int DIV_CNT_W  = 4;

  localparam logic [STEP_W-1:0] STEP_RESET = 19'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 3'd0,
    ACT_PLAY  = 3'd1,
    ACT_PAUSE = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_TICK  = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_RATIO  = 3'd0,
    CFG_FRAME_COUNT = 3'd1,
    CFG_STEREO      = 3'd2,
    CFG_LOOP_ENABLE = 3'd3,
    CFG_LEFT_GAIN   = 3'd4,
    CFG_RIGHT_GAIN  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD0,
    ST_RD1,
    ST_MULD,
    ST_INTERP,
    ST_MULH,
    ST_MULL,
    ST_ACC,
    ST_SAT,
    ST_EMIT
  } state_t;

endpackage

// ----- src/svr_if.sv -----
`timescale 1ns / 1ps
interface svr_in_if;
  logic                                valid;
  logic                                ready;
  logic [svr_pkg::ACTION_W-1:0]        action;
  logic [svr_pkg::LOAD_ADDR_W-1:0]     sample_address;
  logic signed [svr_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, action, sample_address, sample_value, input ready);
  modport sink (input valid, action, sample_address, sample_value, output ready);
endinterface

interface svr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svr_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [svr_pkg::SAMPLE_W-1:0] right_sample;
  logic                                still_playing;

  modport source (output valid, left_sample, right_sample, still_playing, input ready);
  modport sink (input valid, left_sample, right_sample, still_playing, output ready);
endinterface

interface svr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [svr_pkg::CFG_IDX_W-1:0]     index;
  logic [svr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sample_voice_resampler.sv -----
// One sample playback voice with linear interpolation.
// in_if carries requests: load a sample word, play, pause, stop, or tick. Only a
// tick produces a result on out_if (left, right, still_playing); other requests
// complete in the cycle they are accepted. cfg_if writes the six registers and
// is always ready; write it only while the voice has no request in flight.
// A playing tick runs both channels through one shared 17x17 multiplier and a
// single-port sample store: per channel two store reads and three multiplies,
// left channel first, then right. A tick that must wrap the cursor first runs a
// 14-step restoring modulo on the frame index. An idle, paused, empty-buffer or
// end-of-buffer tick skips the reads and gives silence.
// in_if.ready is high only between ticks; loads and commands are taken while a
// result waits on out_if. If the receiver stalls, a finished tick holds in the
// result stage until the output register frees, and in_if stays low meanwhile.
// Reset stops the voice, rewinds the cursor and restores register defaults; the
// sample store is not cleared. SAMPLE_DEPTH must be a power of two.
`timescale 1ns / 1ps
`include "sample_voice_resampler_macros.svh"
module sample_voice_resampler #(
  parameter int SAMPLE_DEPTH  = svr_pkg::DEF_SAMPLE_DEPTH,
  parameter int FRACTION_BITS = svr_pkg::DEF_FRACTION_BITS
) (
  input logic       clk,
  input logic       rst_n,
  svr_in_if.sink    in_if,
  svr_out_if.source out_if,
  svr_cfg_if.sink   cfg_if
);
  import svr_pkg::*;

  localparam int AW       = $clog2(SAMPLE_DEPTH);
  localparam int POS_W    = FRACTION_BITS + POS_INT_W;
  localparam int IW       = FRACTION_BITS + 18;
  localparam int MA_W     = (FRACTION_BITS + 1 > 17) ? FRACTION_BITS + 1 : 17;
  localparam int PW       = MA_W + 17;
  localparam int ACC_W    = FRACTION_BITS + 34;
  localparam int STEP_SHL = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int STEP_SHR = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam logic [ACC_W-1:0] ROUND_C =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRACTION_BITS + 13);

  // Configuration registers.
  logic [STEP_W-1:0] step_r;
  logic [FC_W-1:0]   fc_r;
  logic              stereo_r;
  logic              loop_r;
  logic [GAIN_W-1:0] lgain_r;
  logic [GAIN_W-1:0] rgain_r;

  state_t state_r, state_nxt;
  logic playing_r, playing_nxt;
  logic paused_r, paused_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [FC_W-1:0] idx_r, idx_nxt;
  logic ch_r, ch_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [POS_INT_W-1:0] div_q_r, div_q_nxt;
  logic [FC_W-1:0] div_rem_r, div_rem_nxt;
  logic signed [SAMPLE_W-1:0] s0_r, s0_nxt;
  logic signed [IW-1:0] interp_r, interp_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0] res_left_r, res_left_nxt;
  logic signed [SAMPLE_W-1:0] res_right_r, res_right_nxt;
  logic res_play_r, res_play_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;
  logic out_still_r;
  logic out_load;

  logic signed [PW-1:0] prod_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic [SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic mem_we;
  logic [AW-1:0] mem_addr;

  logic in_acc;
  logic [POS_INT_W-1:0] pos_int;
  logic [POS_INT_W-1:0] fc_ext;
  logic pos_at_end;
  logic [POS_INT_W-1:0] div_t;
  logic [POS_INT_W-1:0] div_sub;
  logic [FC_W-1:0] div_rem_new;
  logic [POS_INT_W-1:0] idx_p1;
  logic [FC_W-1:0] nxt_idx;
  logic [FC_W-1:0] frame_idx;
  logic [POS_INT_W-1:0] word_idx;
  logic [AW+POS_INT_W-1:0] rd_wide;
  logic [AW+LOAD_ADDR_W-1:0] ld_wide;
  logic [POS_W-1:0] step_w;
  logic signed [16:0] diff;
  logic signed [15:0] ih;
  logic [FRACTION_BITS-1:0] il;
  logic [GAIN_W-1:0] gain_sel;
  logic signed [MA_W-1:0] op_a;
  logic signed [16:0] op_b;
  logic signed [19:0] acc_hi;
  logic signed [SAMPLE_W-1:0] sat_val;

  assign in_acc        = in_if.valid && in_if.ready;
  assign in_if.ready   = (state_r == ST_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign out_if.valid  = out_valid_r;
  assign out_if.left_sample   = out_left_r;
  assign out_if.right_sample  = out_right_r;
  assign out_if.still_playing = out_still_r;

  assign pos_int    = pos_r[POS_W-1:FRACTION_BITS];
  assign fc_ext     = {1'b0, fc_r};
  assign pos_at_end = (pos_int >= fc_ext);

  // One restoring step of the frame-index modulo.
  assign div_t       = {div_rem_r, div_q_r[POS_INT_W-1]};
  assign div_sub     = div_t - fc_ext;
  assign div_rem_new = (div_t >= fc_ext) ? div_sub[FC_W-1:0] : div_t[FC_W-1:0];

  // The upper neighbor is clamped to the last frame.
  assign idx_p1    = {1'b0, idx_r} + POS_INT_W'(1);
  assign nxt_idx   = (idx_p1 < fc_ext) ? idx_p1[FC_W-1:0] : idx_r;
  assign frame_idx = (state_r == ST_RD1) ? nxt_idx : idx_r;
  assign word_idx  = stereo_r ? {frame_idx, ch_r} : {1'b0, frame_idx};
  assign rd_wide   = (AW + POS_INT_W)'(word_idx);
  assign ld_wide   = (AW + LOAD_ADDR_W)'(in_if.sample_address);
  assign mem_addr  = (state_r == ST_IDLE) ? ld_wide[AW-1:0] : rd_wide[AW-1:0];

  assign step_w = (POS_W'(step_r) << STEP_SHL) >> STEP_SHR;

  assign diff     = $signed({rdata_r[15], rdata_r}) - $signed({s0_r[15], s0_r});
  assign ih       = interp_r[FRACTION_BITS+15:FRACTION_BITS];
  assign il       = interp_r[FRACTION_BITS-1:0];
  assign gain_sel = ch_r ? rgain_r : lgain_r;

  always_comb begin
    op_a = MA_W'($signed({1'b0, il}));
    op_b = $signed({1'b0, gain_sel});
    case (state_r)
      ST_MULD: begin
        op_a = MA_W'($signed({1'b0, pos_r[FRACTION_BITS-1:0]}));
        op_b = diff;
      end
      ST_MULH: op_a = MA_W'(ih);
      default: ;
    endcase
  end

  assign acc_hi = acc_r[ACC_W-1:FRACTION_BITS+14];

  always_comb begin
    if (acc_hi > 20'sd32767) begin
      sat_val = 16'sh7fff;
    end else if (acc_hi < -20'sd32768) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = acc_hi[15:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    playing_nxt   = playing_r;
    paused_nxt    = paused_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    ch_nxt        = ch_r;
    div_cnt_nxt   = div_cnt_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    s0_nxt        = s0_r;
    interp_nxt    = interp_r;
    acc_nxt       = acc_r;
    res_left_nxt  = res_left_r;
    res_right_nxt = res_right_r;
    res_play_nxt  = res_play_r;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_if.action)
            ACT_LOAD: mem_we = 1'b1;
            ACT_PLAY: begin
              playing_nxt = 1'b1;
              paused_nxt  = 1'b0;
            end
            ACT_PAUSE: paused_nxt = 1'b1;
            ACT_STOP: begin
              playing_nxt = 1'b0;
              paused_nxt  = 1'b0;
              pos_nxt     = '0;
            end
            ACT_TICK: begin
              res_left_nxt  = '0;
              res_right_nxt = '0;
              res_play_nxt  = 1'b0;
              ch_nxt        = 1'b0;
              if (!playing_r || paused_r) begin
                state_nxt = ST_EMIT;
              end else if (pos_at_end) begin
                if (fc_r != '0 && loop_r) begin
                  div_q_nxt   = pos_int;
                  div_rem_nxt = '0;
                  div_cnt_nxt = DIV_CNT_W'(DIV_STEPS - 1);
                  state_nxt   = ST_MOD;
                end else begin
                  playing_nxt = 1'b0;
                  pos_nxt     = '0;
                  state_nxt   = ST_EMIT;
                end
              end else begin
                idx_nxt   = pos_int[FC_W-1:0];
                state_nxt = ST_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        div_rem_nxt = div_rem_new;
        div_q_nxt   = div_q_r << 1;
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == '0) begin
          // The wrapped cursor keeps its fraction.
          pos_nxt   = {1'b0, div_rem_new, pos_r[FRACTION_BITS-1:0]};
          idx_nxt   = div_rem_new;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: begin
        s0_nxt    = rdata_r;
        state_nxt = ST_MULD;
      end
      ST_MULD: state_nxt = ST_INTERP;
      ST_INTERP: begin
        interp_nxt = (IW'(s0_r) <<< FRACTION_BITS) + IW'(prod_r);
        state_nxt  = ST_MULH;
      end
      ST_MULH: state_nxt = ST_MULL;
      ST_MULL: begin
        // The high half of the interpolated value is weighted by 2^F.
        acc_nxt   = (ACC_W'(prod_r) <<< FRACTION_BITS) + $signed(ROUND_C);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (!ch_r) begin
          res_left_nxt = sat_val;
          ch_nxt       = 1'b1;
          state_nxt    = ST_RD0;
        end else begin
          res_right_nxt = sat_val;
          res_play_nxt  = 1'b1;
          pos_nxt       = pos_r + step_w;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_if.ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      playing_r   <= 1'b0;
      paused_r    <= 1'b0;
      pos_r       <= '0;
      ch_r        <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
      fc_r        <= '0;
      stereo_r    <= 1'b0;
      loop_r      <= 1'b0;
      lgain_r     <= GAIN_RESET;
      rgain_r     <= GAIN_RESET;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      paused_r    <= paused_nxt;
      pos_r       <= pos_nxt;
      ch_r        <= ch_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        unique case (cfg_if.index)
          CFG_STEP_RATIO:  step_r   <= cfg_if.data[STEP_W-1:0];
          CFG_FRAME_COUNT: fc_r     <= cfg_if.data[FC_W-1:0];
          CFG_STEREO:      stereo_r <= cfg_if.data[0];
          CFG_LOOP_ENABLE: loop_r   <= cfg_if.data[0];
          CFG_LEFT_GAIN:   lgain_r  <= cfg_if.data[GAIN_W-1:0];
          CFG_RIGHT_GAIN:  rgain_r  <= cfg_if.data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    s0_r        <= s0_nxt;
    interp_r    <= interp_nxt;
    acc_r       <= acc_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    res_play_r  <= res_play_nxt;
    prod_r      <= op_a * op_b;
    if (out_load) begin
      out_left_r  <= res_left_r;
      out_right_r <= res_right_r;
      out_still_r <= res_play_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_if.sample_value;
    end
    rdata_r <= mem[mem_addr];
  end

  `SVR_ASSERT_IMP(a_silent_when_stopped, out_valid_r && !out_still_r,
                  out_left_r == '0 && out_right_r == '0,
                  "A stopped or idle tick must give silence.")
  `SVR_ASSERT_IMP(a_wrap_only_when_playing, state_r == ST_MOD,
                  playing_r && !paused_r && loop_r,
                  "The cursor wrap ran on a voice that is not looping and playing.")
  `SVR_ASSERT_NXT(a_emit_waits_for_slot,
                  state_r == ST_EMIT && out_valid_r && !out_if.ready,
                  state_r == ST_EMIT && out_valid_r,
                  "A finished tick left the result stage while the output was full.")
  `SVR_ASSERT_NXT(a_wrap_then_read, state_r == ST_MOD && div_cnt_r == '0,
                  state_r == ST_RD0 && !ch_r,
                  "The cursor wrap did not hand over to the left-channel reads.")

endmodule
